[hdl/barycentric_force_scatter_defines.svh]
// assertion macros shared by the checker
`ifndef BARYCENTRIC_FORCE_SCATTER_DEFINES_SVH
`define BARYCENTRIC_FORCE_SCATTER_DEFINES_SVH
`define BFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfs check failed");
`define BFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfs check failed");
`endif

[hdl/bfs_pkg.sv]
// ---------------------------------------------------------------------------
// bfs_pkg
// types and constants for the barycentric force scatter
// ---------------------------------------------------------------------------
package bfs_pkg;
    localparam int unsigned NUM_VERTICES_DEF = 1024;
    localparam int unsigned VIDX_W = 10;
    localparam logic [30:0] PULL_RESET = 31'd65536;

    typedef enum logic [1:0] {
        FUNC_APPLY = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_NORM, ST_SQUARE, ST_SQRT, ST_DIV,
        ST_SCAT_RD, ST_SCAT_MUL, ST_SCAT_WR, ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]        func;
        logic              tip_active;
        logic signed [31:0] tip_x;
        logic signed [31:0] tip_y;
        logic signed [31:0] tip_z;
        logic [9:0]        vert_a;
        logic [9:0]        vert_b;
        logic [9:0]        vert_c;
        logic [16:0]       bary_a;
        logic [16:0]       bary_b;
        logic [16:0]       bary_c;
    } in_word_t;

    typedef struct packed {
        logic              applied;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } out_word_t;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [49:0] b);
        logic signed [50:0] s;
        s = 51'(a) + 51'(b);
        if (s > 51'sd2147483647)
            return 32'sh7fffffff;
        else if (s < -51'sd2147483648)
            return 32'sh80000000;
        else
            return s[31:0];
    endfunction
endpackage

[hdl/bfs_if.sv]
// ---------------------------------------------------------------------------
// bfs_in_if / bfs_out_if
// valid/ready channels carrying input and result words
// ---------------------------------------------------------------------------
interface bfs_in_if;
    logic valid;
    logic ready;
    bfs_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bfs_out_if;
    logic valid;
    logic ready;
    bfs_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/barycentric_force_scatter.sv]
// sequence: read, clear and unused codes go from accept to the result state; an inactive or zero
// offset passes the normalise state first; apply normalises by a shift k of 0 to 30, then runs 3
// squares, a square root, 3 divides, and a read-modify-write per vertex or a skip per skipped one
// throughput: one word at a time; the next word is taken once the result is accepted
// reset: async active low; a clearing pass zeroes the force memories before the first word
// is taken, pull_force returns to 1.0
// ---------------------------------------------------------------------------
// barycentric_force_scatter
// scatters normalised pull forces into per-vertex accumulators in memory
// ---------------------------------------------------------------------------
module barycentric_force_scatter #(
    parameter int unsigned NUM_VERTICES = bfs_pkg::NUM_VERTICES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    bfs_in_if.sink      in_ch,
    bfs_out_if.source   out_ch
);
    localparam int unsigned AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;

    logic signed [31:0] mem_x [NUM_VERTICES];
    logic signed [31:0] mem_y [NUM_VERTICES];
    logic signed [31:0] mem_z [NUM_VERTICES];
    logic signed [31:0] rd_x_reg, rd_y_reg, rd_z_reg;
    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic signed [31:0] wd_x, wd_y, wd_z;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_x[waddr] <= wd_x;
            mem_y[waddr] <= wd_y;
            mem_z[waddr] <= wd_z;
        end
        rd_x_reg <= mem_x[raddr];
        rd_y_reg <= mem_y[raddr];
        rd_z_reg <= mem_z[raddr];
    end

    bfs_pkg::state_t    state_reg, state_next;
    logic [30:0]        pull_reg;
    bfs_pkg::in_word_t  item_reg, item_next;
    bfs_pkg::out_word_t res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic [AW:0]        clr_reg, clr_next;
    logic [63:0]        m0_reg, m0_next, m1_reg, m1_next, m2_reg, m2_next;
    logic [63:0]        rem_reg, rem_next, root_reg, root_next, bit_reg, bit_next;
    logic [63:0]        num_reg, num_next, q_reg, q_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [1:0]         ax_reg, ax_next, vx_reg, vx_next;
    logic signed [49:0] wx_reg, wx_next, wy_reg, wy_next, wz_reg, wz_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pull_reg <= bfs_pkg::PULL_RESET;
        else if (cfg_we)
            pull_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfs_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        m0_reg <= m0_next; m1_reg <= m1_next; m2_reg <= m2_next;
        rem_reg <= rem_next; root_reg <= root_next; bit_reg <= bit_next;
        num_reg <= num_next; q_reg <= q_next; cnt_reg <= cnt_next;
        ax_reg <= ax_next; vx_reg <= vx_next;
        wx_reg <= wx_next; wy_reg <= wy_next; wz_reg <= wz_next;
    end

    assign in_ch.ready  = (state_reg == bfs_pkg::ST_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = res_reg;

    logic [31:0] mag_x, mag_y, mag_z;
    logic [63:0] mx, cur_m, sq, trial, dsub;
    logic [9:0]  cur_v;
    logic [16:0] cur_w;
    logic [63:0] wprod;
    logic [47:0] wmag;
    logic signed [31:0] cur_f;
    logic [32:0] fmag;

    always_comb
    begin
        mag_x = item_reg.tip_x[31] ? 32'(-item_reg.tip_x) : 32'(item_reg.tip_x);
        mag_y = item_reg.tip_y[31] ? 32'(-item_reg.tip_y) : 32'(item_reg.tip_y);
        mag_z = item_reg.tip_z[31] ? 32'(-item_reg.tip_z) : 32'(item_reg.tip_z);
        mx = m0_reg;
        if (m1_reg > mx) mx = m1_reg;
        if (m2_reg > mx) mx = m2_reg;
        case (ax_reg)
            2'd0:    cur_m = m0_reg;
            2'd1:    cur_m = m1_reg;
            default: cur_m = m2_reg;
        endcase
        sq    = cur_m[31:0] * cur_m[31:0];
        trial = root_reg + bit_reg;
        dsub  = {rem_reg[62:0], num_reg[63]};
        case (vx_reg)
            2'd0:    begin cur_v = item_reg.vert_a; cur_w = item_reg.bary_a; end
            2'd1:    begin cur_v = item_reg.vert_b; cur_w = item_reg.bary_b; end
            default: begin cur_v = item_reg.vert_c; cur_w = item_reg.bary_c; end
        endcase
        case (ax_reg)
            2'd0:    cur_f = res_reg.force_x;
            2'd1:    cur_f = res_reg.force_y;
            default: cur_f = res_reg.force_z;
        endcase
        fmag  = cur_f[31] ? 33'(-34'(cur_f)) : 33'(cur_f);
        wprod = 64'(fmag) * 64'(cur_w);
        wmag  = 48'((wprod + 64'd32768) >> 16);
    end

    always_comb
    begin
        state_next = state_reg; out_valid_next = out_valid_reg; clr_next = clr_reg;
        item_next = item_reg; res_next = res_reg;
        m0_next = m0_reg; m1_next = m1_reg; m2_next = m2_reg;
        rem_next = rem_reg; root_next = root_reg; bit_next = bit_reg;
        num_next = num_reg; q_next = q_reg; cnt_next = cnt_reg;
        ax_next = ax_reg; vx_next = vx_reg;
        wx_next = wx_reg; wy_next = wy_reg; wz_next = wz_reg;
        we = 1'b0; waddr = clr_reg[AW-1:0]; raddr = AW'(item_reg.vert_a);
        wd_x = '0; wd_y = '0; wd_z = '0;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            bfs_pkg::ST_CLEAR:
            begin
                we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(NUM_VERTICES - 1))
                    state_next = bfs_pkg::ST_IDLE;
            end
            bfs_pkg::ST_IDLE:
            begin
                raddr = AW'(in_ch.data.vert_a);
                if (in_ch.valid && in_ch.ready)
                begin
                    item_next = in_ch.data;
                    res_next  = '0;
                    m0_next = '0; m1_next = '0; m2_next = '0;
                    ax_next = 2'd0; vx_next = 2'd0;
                    unique case (bfs_pkg::func_t'(in_ch.data.func))
                        bfs_pkg::FUNC_APPLY: state_next = bfs_pkg::ST_NORM;
                        bfs_pkg::FUNC_READ,
                        bfs_pkg::FUNC_CLEAR: state_next = bfs_pkg::ST_OUT;
                        default:             state_next = bfs_pkg::ST_OUT;
                    endcase
                    cnt_next = 6'd0;
                end
            end
            bfs_pkg::ST_NORM:
            begin
                // first cycle loads magnitudes, then shift one bit a cycle
                if (cnt_reg == 6'd0)
                begin
                    m0_next = 64'(mag_x); m1_next = 64'(mag_y); m2_next = 64'(mag_z);
                    cnt_next = 6'd1;
                    if (!item_reg.tip_active || (mag_x | mag_y | mag_z) == 32'd0)
                    begin
                        res_next = '0;
                        state_next = bfs_pkg::ST_OUT;
                    end
                end
                else if (mx < 64'h4000_0000)
                begin
                    m0_next = m0_reg << 1; m1_next = m1_reg << 1; m2_next = m2_reg << 1;
                end
                else
                begin
                    rem_next = '0; ax_next = 2'd0;
                    state_next = bfs_pkg::ST_SQUARE;
                end
            end
            bfs_pkg::ST_SQUARE:
            begin
                rem_next = rem_reg + sq;
                if (ax_reg == 2'd2)
                begin
                    root_next = '0; bit_next = 64'd1 << 62;
                    state_next = bfs_pkg::ST_SQRT;
                end
                else
                    ax_next = ax_reg + 2'd1;
            end
            bfs_pkg::ST_SQRT:
            begin
                // rem holds n, one result bit per cycle
                if (bit_reg == 64'd0)
                begin
                    ax_next = 2'd0; cnt_next = 6'd0;
                    num_next = m0_reg[31:0] * 64'(pull_reg) + (root_reg >> 1);
                    rem_next = 64'd0; q_next = '0;
                    state_next = bfs_pkg::ST_DIV;
                end
                else
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_next  = rem_reg - trial;
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                        root_next = root_reg >> 1;
                    bit_next = bit_reg >> 2;
                end
            end
            bfs_pkg::ST_DIV:
            begin
                // restoring divide by root, one bit per cycle over 64 bits
                num_next = num_reg << 1;
                if (dsub >= root_reg)
                begin
                    rem_next = dsub - root_reg;
                    q_next   = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = dsub;
                    q_next   = {q_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    case (ax_reg)
                        2'd0: res_next.force_x = (item_reg.tip_x > 0) ?
                                  -32'(q_next) : 32'(q_next);
                        2'd1: res_next.force_y = (item_reg.tip_y > 0) ?
                                  -32'(q_next) : 32'(q_next);
                        default: res_next.force_z = (item_reg.tip_z > 0) ?
                                  -32'(q_next) : 32'(q_next);
                    endcase
                    rem_next = '0; q_next = '0;
                    case (ax_reg)
                        2'd0:    num_next = m1_reg[31:0] * 64'(pull_reg) + (root_reg >> 1);
                        default: num_next = m2_reg[31:0] * 64'(pull_reg) + (root_reg >> 1);
                    endcase
                    if (ax_reg == 2'd2)
                    begin
                        res_next.applied = 1'b1;
                        vx_next = 2'd0;
                        state_next = bfs_pkg::ST_SCAT_RD;
                    end
                    else
                        ax_next = ax_reg + 2'd1;
                end
            end
            bfs_pkg::ST_SCAT_RD:
            begin
                raddr = AW'(cur_v);
                ax_next = 2'd0;
                if (32'(cur_v) >= NUM_VERTICES)
                begin
                    if (vx_reg == 2'd2)
                        state_next = bfs_pkg::ST_OUT;
                    else
                        vx_next = vx_reg + 2'd1;
                end
                else
                    state_next = bfs_pkg::ST_SCAT_MUL;
            end
            bfs_pkg::ST_SCAT_MUL:
            begin
                // one weighted component per cycle
                raddr = AW'(cur_v);
                case (ax_reg)
                    2'd0: wx_next = cur_f[31] ? -50'(wmag) : 50'(wmag);
                    2'd1: wy_next = cur_f[31] ? -50'(wmag) : 50'(wmag);
                    default: wz_next = cur_f[31] ? -50'(wmag) : 50'(wmag);
                endcase
                if (ax_reg == 2'd2)
                    state_next = bfs_pkg::ST_SCAT_WR;
                else
                    ax_next = ax_reg + 2'd1;
            end
            bfs_pkg::ST_SCAT_WR:
            begin
                we = 1'b1; waddr = AW'(cur_v);
                wd_x = bfs_pkg::sat_add(rd_x_reg, wx_reg);
                wd_y = bfs_pkg::sat_add(rd_y_reg, wy_reg);
                wd_z = bfs_pkg::sat_add(rd_z_reg, wz_reg);
                if (vx_reg == 2'd2)
                    state_next = bfs_pkg::ST_OUT;
                else
                begin
                    vx_next = vx_reg + 2'd1;
                    state_next = bfs_pkg::ST_SCAT_RD;
                end
            end
            bfs_pkg::ST_OUT:
            begin
                if (bfs_pkg::func_t'(item_reg.func) == bfs_pkg::FUNC_READ &&
                    32'(item_reg.vert_a) < NUM_VERTICES)
                begin
                    res_next.force_x = rd_x_reg;
                    res_next.force_y = rd_y_reg;
                    res_next.force_z = rd_z_reg;
                end
                if (bfs_pkg::func_t'(item_reg.func) == bfs_pkg::FUNC_CLEAR &&
                    32'(item_reg.vert_a) < NUM_VERTICES)
                begin
                    we = 1'b1; waddr = AW'(item_reg.vert_a);
                end
                out_valid_next = 1'b1;
                state_next = bfs_pkg::ST_IDLE;
            end
            default: state_next = bfs_pkg::ST_IDLE;
        endcase
    end
endmodule

[hdl/bfs_checker.sv]
// ---------------------------------------------------------------------------
// bfs_checker
// port-level checks on the force scatter channels
// ---------------------------------------------------------------------------
`include "barycentric_force_scatter_defines.svh"
module bfs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_applied,
    input logic [31:0] out_fx
);
    // held result stays valid until taken
    `BFS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // never take a word while a result waits
    `BFS_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    // a word taken leaves the input not ready in the very next cycle
    `BFS_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
    // a waiting result word keeps its applied flag and x force
    `BFS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_fx) && $stable(out_applied))
endmodule

bind barycentric_force_scatter bfs_checker u_bfs_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_applied(out_ch.data.applied), .out_fx(out_ch.data.force_x)
);
